[hdl/sfc_pkg.sv]
// Shared types and constants of the stereo FIR convolver.
`default_nettype none
package sfc_pkg;

	localparam int TAPS        = 128;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 16;
	localparam int TAP_BITS    = 7;
	localparam int AW          = $clog2(TAPS);
	localparam int FRAC        = COEF_BITS - 2;
	localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W       = SAMPLE_BITS + COEF_BITS + AW;

	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_COEF   = 1'b1;
	localparam logic EAR_LEFT   = 1'b0;
	localparam logic EAR_RIGHT  = 1'b1;

	typedef struct packed {
		logic                          req_type;
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic                          frame_last;
		logic                          coef_ear;
		logic [TAP_BITS-1:0]           coef_tap;
		logic signed [COEF_BITS-1:0]   coef_value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          frame_last_out;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[hdl/sfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/stereo_fir_convolver.sv]
// Flow: a sample word accepted in ST_IDLE walks the taps in ST_RUN, one read port
//   per memory feeding two MACs, then ST_DRAIN and ST_OUT load its result; cmd_stall
//   is high outside ST_IDLE, and a coefficient word is written without leaving it.
// Reset: asynchronous, active low; a clearing pass over every address then zeroes the
//   delay line and both coefficient memories, with cmd_stall high.
`default_nettype none
module stereo_fir_convolver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  sfc_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output sfc_pkg::rsp_word_t rsp
);
	import sfc_pkg::*;

	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
	localparam int RND_W = ACC_W + 1;
	localparam int SH_W  = RND_W - FRAC;

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
		input logic signed [ACC_W-1:0] a
	);
		logic signed [RND_W-1:0] r;
		logic signed [SH_W-1:0]  s;
		r = {a[ACC_W-1], a} + {{(RND_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
		s = r[RND_W-1:FRAC];
		if (s[SH_W-1:SAMPLE_BITS-1] == '0 || s[SH_W-1:SAMPLE_BITS-1] == '1) begin
			round_sat = s[SAMPLE_BITS-1:0];
		end else if (s[SH_W-1]) begin
			round_sat = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0] head_q, rd_ptr_q, cnt_q;
	logic [AW-1:0] next_head, prev_ptr, next_cnt;
	logic          flag_q;
	logic          accept, tap_ok;

	logic                   hist_we, lc_we, rc_we, rd_en;
	logic [AW-1:0]          hist_waddr, coef_waddr;
	logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;
	logic [COEF_BITS-1:0]   coef_wdata, lc_rdata, rc_rdata;

	logic                      v_s1, v_s2, last_s1, last_s2;
	logic signed [PROD_W-1:0]  prod_l_s2, prod_r_s2;
	logic signed [ACC_W-1:0]   acc_l_q, acc_r_q;

	logic      rsp_load, rsp_valid_q;
	rsp_word_t rsp_q;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign tap_ok    = int'(cmd.coef_tap) < TAPS;
	assign next_head = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign prev_ptr  = (rd_ptr_q == '0) ? LAST : rd_ptr_q - 1'b1;
	assign next_cnt  = (cnt_q == LAST) ? '0 : cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		hist_we    = 1'b0;
		hist_waddr = cnt_q;
		hist_wdata = '0;
		lc_we      = 1'b0;
		rc_we      = 1'b0;
		coef_waddr = cnt_q;
		coef_wdata = '0;
		rd_en      = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				lc_we   = 1'b1;
				rc_we   = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (cmd.req_type == REQ_COEF) begin
						coef_waddr = AW'(cmd.coef_tap);
						coef_wdata = cmd.coef_value;
						lc_we      = tap_ok && (cmd.coef_ear == EAR_LEFT);
						rc_we      = tap_ok && (cmd.coef_ear == EAR_RIGHT);
					end else begin
						hist_we    = 1'b1;
						hist_waddr = next_head;
						hist_wdata = cmd.sample_in;
						state_d    = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				rd_en = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (last_s2) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			head_q   <= '0;
			rd_ptr_q <= '0;
			flag_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= next_cnt;
				end
				ST_IDLE: begin
					if (accept && cmd.req_type == REQ_SAMPLE) begin
						head_q   <= next_head;
						rd_ptr_q <= next_head;
						cnt_q    <= '0;
						flag_q   <= cmd.frame_last;
					end
				end
				ST_RUN: begin
					cnt_q    <= next_cnt;
					rd_ptr_q <= prev_ptr;
				end
				default: ;
			endcase
		end
	end

	sfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAPS)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (hist_rdata)
	);

	sfc_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_left_coef (
		.clk   (clk),
		.we    (lc_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (rd_en),
		.raddr (cnt_q),
		.rdata (lc_rdata)
	);

	sfc_ram #(.WIDTH(COEF_BITS), .DEPTH(TAPS)) u_right_coef (
		.clk   (clk),
		.we    (rc_we),
		.waddr (coef_waddr),
		.wdata (coef_wdata),
		.re    (rd_en),
		.raddr (cnt_q),
		.rdata (rc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= rd_en;
			last_s1 <= rd_en && (cnt_q == LAST);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	// MAC pipeline: product register, then exact accumulation
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_l_s2 <= $signed(hist_rdata) * $signed(lc_rdata);
			prod_r_s2 <= $signed(hist_rdata) * $signed(rc_rdata);
		end
		if (accept && cmd.req_type == REQ_SAMPLE) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else if (v_s2) begin
			acc_l_q <= acc_l_q + ACC_W'(prod_l_s2);
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.left_out       <= round_sat(acc_l_q);
			rsp_q.right_out      <= round_sat(acc_r_q);
			rsp_q.frame_last_out <= flag_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result word appeared outside the output step");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |-> state_q == ST_DRAIN)
		else $error("last product accumulated outside drain");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && !v_s2)
		else $error("MAC pipeline busy while idle");

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !hist_we && !lc_we && !rc_we)
		else $error("memory write during tap walk");

	a_clear_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !rsp_valid_q)
		else $error("result word during clearing pass");

endmodule
`default_nettype wire

[tb/stereo_fir_checker.sv]
// Predictor and scoreboard for the stereo FIR convolver response words.
module stereo_fir_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  sfc_pkg::cmd_word_t cmd,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  sfc_pkg::rsp_word_t rsp,
	output int                 fail_count,
	output int                 pending
);
	import sfc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] delay_line [TAPS];
	logic signed [COEF_BITS-1:0]   left_taps  [TAPS];
	logic signed [COEF_BITS-1:0]   right_taps [TAPS];
	rsp_word_t                     due_words  [$];
	int                            errs = 0;

	assign fail_count = errs;

	// exact dot product, round half up, saturate to the sample range
	function automatic logic signed [SAMPLE_BITS-1:0] ear_sample(input logic ear);
		longint acc;
		longint peak;
		acc  = 0;
		peak = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		for (int k = 0; k < TAPS; k++)
			acc += longint'(delay_line[k]) *
				longint'((ear == EAR_RIGHT) ? right_taps[k] : left_taps[k]);
		acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		if (acc > peak)
			acc = peak;
		else if (acc < -peak - 1)
			acc = -peak - 1;
		return acc[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				delay_line[k] = '0;
				left_taps[k]  = '0;
				right_taps[k] = '0;
			end
			due_words.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_words.size() == 0) begin
					errs++;
					$display("%0t: response word with none due: expected nothing, got %h",
						$time, rsp);
				end else begin
					want = due_words.pop_front();
					if (rsp.left_out !== want.left_out) begin
						errs++;
						$display("%0t: left_out expected %0d got %0d",
							$time, want.left_out, rsp.left_out);
					end
					if (rsp.right_out !== want.right_out) begin
						errs++;
						$display("%0t: right_out expected %0d got %0d",
							$time, want.right_out, rsp.right_out);
					end
					if (rsp.frame_last_out !== want.frame_last_out) begin
						errs++;
						$display("%0t: frame_last_out expected %0d got %0d",
							$time, want.frame_last_out, rsp.frame_last_out);
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd.req_type == REQ_COEF) begin
					if (cmd.coef_tap < TAPS) begin
						if (cmd.coef_ear == EAR_RIGHT)
							right_taps[cmd.coef_tap] = cmd.coef_value;
						else
							left_taps[cmd.coef_tap] = cmd.coef_value;
					end
				end else begin
					for (int k = TAPS - 1; k > 0; k--)
						delay_line[k] = delay_line[k-1];
					delay_line[0] = cmd.sample_in;
					want.left_out       = ear_sample(EAR_LEFT);
					want.right_out      = ear_sample(EAR_RIGHT);
					want.frame_last_out = cmd.frame_last;
					due_words.push_back(want);
				end
			end
			pending <= due_words.size();
		end
	end

endmodule

[tb/stereo_fir_convolver_tb.sv]
// Stimulus and verdict for the stereo FIR convolver, checked by stereo_fir_checker.
module stereo_fir_convolver_tb;
	import sfc_pkg::*;

	localparam int S_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int S_MIN  = -(1 << (SAMPLE_BITS - 1));
	localparam int C_MAX  = (1 << (COEF_BITS - 1)) - 1;
	localparam int C_MIN  = -(1 << (COEF_BITS - 1));
	localparam int N_WORDS = 1400;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;
	int        fails;
	int        pending;
	int        words_sent = 0;
	bit        calm = 1'b0;

	always #2 clk = ~clk;

	stereo_fir_convolver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	stereo_fir_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fails),
		.pending    (pending)
	);

	// uniform in [-2^mag, 2^mag - 1]
	function automatic int rnd_span(input int mag);
		return int'($urandom_range(0, (1 << (mag + 1)) - 1)) - (1 << mag);
	endfunction

	function automatic cmd_word_t sample_word(input int s, input logic fl);
		cmd_word_t w;
		w.req_type   = REQ_SAMPLE;
		w.sample_in  = s[SAMPLE_BITS-1:0];
		w.frame_last = fl;
		w.coef_ear   = 1'($urandom);
		w.coef_tap   = TAP_BITS'($urandom);
		w.coef_value = COEF_BITS'($urandom);
		return w;
	endfunction

	function automatic cmd_word_t coef_word(input logic ear, input int tap, input int c);
		cmd_word_t w;
		w.req_type   = REQ_COEF;
		w.sample_in  = SAMPLE_BITS'($urandom);
		w.frame_last = 1'($urandom);
		w.coef_ear   = ear;
		w.coef_tap   = tap[TAP_BITS-1:0];
		w.coef_value = c[COEF_BITS-1:0];
		return w;
	endfunction

	task automatic send(input cmd_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic drain_wait();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic int coef_value(input int mode);
		if (mode == 0)
			return ($urandom_range(0, 7) == 0) ? (($urandom & 1) ? C_MAX : C_MIN)
				: rnd_span(COEF_BITS - 1);
		return rnd_span(mode == 1 ? 10 : 6);
	endfunction

	function automatic int sample_value(input int mode);
		case (mode)
			0: return ($urandom_range(0, 9) == 0) ? (($urandom & 1) ? S_MAX : S_MIN)
				: rnd_span(SAMPLE_BITS - 1);
			1: return rnd_span(12);
			default: begin
				case ($urandom_range(0, 3))
					0: return S_MAX;
					1: return S_MIN;
					2: return 0;
					default: return -1;
				endcase
			end
		endcase
	endfunction

	// receiver: random stall before each response word
	initial begin
		int hold;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 19);
			repeat (hold) begin
				rsp_stall <= 1'b1;
				@(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	initial begin
		int kind;
		int n;
		int mode;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero store, saturation both ways, rounding at half LSB, last tap
		send(sample_word(S_MAX, 1'b1));
		send(coef_word(EAR_LEFT, 0, C_MAX));
		send(coef_word(EAR_RIGHT, 0, C_MIN));
		send(sample_word(S_MAX, 1'b0));
		send(sample_word(S_MIN, 1'b1));
		send(coef_word(EAR_LEFT, 0, 1));
		send(coef_word(EAR_RIGHT, 0, -1));
		send(sample_word(8192, 1'b0));
		send(sample_word(-8192, 1'b0));
		send(sample_word(24576, 1'b1));
		send(sample_word(-24576, 1'b0));
		send(sample_word(0, 1'b0));
		send(coef_word(EAR_LEFT, TAPS - 1, 16384));
		send(coef_word(EAR_RIGHT, TAPS - 1, -16384));
		send(sample_word(S_MIN, 1'b1));
		send(coef_word(EAR_LEFT, TAPS - 1, C_MIN));
		send(coef_word(EAR_RIGHT, TAPS - 1, C_MAX));
		send(sample_word(S_MAX, 1'b0));
		drain_wait();

		// random: one quiet sweep first so every tap gets a value on a randomly chosen ear
		mode = 2;
		for (int t = 0; t < TAPS; t++)
			send(coef_word(1'($urandom), t, coef_value(mode)));
		while (words_sent < N_WORDS) begin
			calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 11);
			if (kind == 0) begin
				mode = $urandom_range(1, 2);
				n    = $urandom & 1;
				for (int t = 0; t < TAPS; t++)
					send(coef_word(n[0], t, coef_value(mode)));
			end else if (kind <= 3) begin
				mode = $urandom_range(0, 2);
				repeat ($urandom_range(1, 40))
					send(coef_word(1'($urandom), $urandom_range(0, TAPS - 1),
						coef_value(mode)));
			end else if (kind == 4) begin
				drain_wait();
			end else begin
				mode = $urandom_range(0, 3);
				repeat ($urandom_range(5, 30))
					send(sample_word(sample_value(mode == 3 ? 0 : mode), 1'($urandom)));
			end
		end

		calm = 1'b0;
		drain_wait();
		repeat (TAPS + 8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[stereo_fir_convolver] OK");
		else
			$display("[stereo_fir_convolver] ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("[stereo_fir_convolver] ERROR");
		$finish;
	end

endmodule

[stereo_fir_convolver.f]
hdl/sfc_pkg.sv
hdl/sfc_ram.sv
hdl/stereo_fir_convolver.sv
tb/stereo_fir_checker.sv
tb/stereo_fir_convolver_tb.sv
